@@ rtl/core/integer_to_roman_numeral_core_macros.svh @@
// assertion macros shared by the roman numeral core modules
`ifndef INTEGER_TO_ROMAN_NUMERAL_CORE_MACROS_SVH
`define INTEGER_TO_ROMAN_NUMERAL_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define I2R_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define I2R_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

@@ rtl/core/i2r_pkg.sv @@
// shared constants, types and symbol table of the roman numeral core
`default_nettype none

package i2r_pkg;

	localparam int VAL_W          = 12;
	localparam int DEF_VALUE_BITS = 12;
	localparam int MAX_CHARS      = 15;
	localparam int LEN_W          = 5;
	localparam int CFG_W          = 7;
	localparam int SYM_W          = 8;
	localparam int SYM_N          = 13;
	localparam int IDX_W          = 4;
	localparam int ADDR_W         = 3;
	localparam int DATA_W         = 32;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [CFG_W-1:0]    BUF_SIZE_RESET  = 7'd16;
	localparam logic [ADDR_W-3:0]   REG_BUFFER_SIZE = '0;

	typedef logic [IDX_W-1:0] sym_idx_t;

	function automatic logic [VAL_W-1:0] sym_val(input sym_idx_t idx);
		logic [VAL_W-1:0] v;
		case (idx)
			4'd0:    v = 12'd1000;
			4'd1:    v = 12'd900;
			4'd2:    v = 12'd500;
			4'd3:    v = 12'd400;
			4'd4:    v = 12'd100;
			4'd5:    v = 12'd90;
			4'd6:    v = 12'd50;
			4'd7:    v = 12'd40;
			4'd8:    v = 12'd10;
			4'd9:    v = 12'd9;
			4'd10:   v = 12'd5;
			4'd11:   v = 12'd4;
			default: v = 12'd1;
		endcase
		return v;
	endfunction

	function automatic logic [SYM_W-1:0] sym_hi(input sym_idx_t idx);
		logic [SYM_W-1:0] c;
		case (idx)
			4'd0:    c = "M";
			4'd1:    c = "C";
			4'd2:    c = "D";
			4'd3:    c = "C";
			4'd4:    c = "C";
			4'd5:    c = "X";
			4'd6:    c = "L";
			4'd7:    c = "X";
			4'd8:    c = "X";
			4'd9:    c = "I";
			4'd10:   c = "V";
			default: c = "I";
		endcase
		return c;
	endfunction

	// second letter of a subtractive pair, zero for a single letter
	function automatic logic [SYM_W-1:0] sym_lo(input sym_idx_t idx);
		logic [SYM_W-1:0] c;
		case (idx)
			4'd1:    c = "M";
			4'd3:    c = "D";
			4'd5:    c = "C";
			4'd7:    c = "L";
			4'd9:    c = "X";
			4'd11:   c = "V";
			default: c = '0;
		endcase
		return c;
	endfunction

	// largest table entry not above n
	function automatic sym_idx_t sym_sel(input logic [VAL_W-1:0] n);
		sym_idx_t sel;
		sel = IDX_W'(SYM_N - 1);
		for (int i = SYM_N - 1; i >= 0; i--) begin
			if (n >= sym_val(IDX_W'(i)))
				sel = IDX_W'(i);
		end
		return sel;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/i2r_ifs.sv @@
// value and numeral channel interfaces
`default_nettype none

interface i2r_value_if;
	import i2r_pkg::*;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface i2r_numeral_if;
	import i2r_pkg::*;
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last;
	logic             ok;

	modport source (output valid, output symbol, output last, output ok, input ready);
	modport sink   (input valid, input symbol, input last, input ok, output ready);
endinterface

`default_nettype wire

@@ rtl/core/integer_to_roman_numeral_core.sv @@
// top level of the integer to roman numeral converter
//
//   channel      dir   payload                  handshake
//   value_ch     in    value[11:0]              valid/ready
//   numeral_ch   out   symbol[7:0], last, ok    valid/ready
//   apb          in    buffer_size at 0x0       psel/penable, pready tied high
//
// the front takes one numeral symbol per cycle; the back sends one character per cycle
// while the numeral channel is ready, after loading the item from the queue
// a numeral that passes has at most 15 characters
// a two-entry queue lets either end stall; a failure is one item
// arst_n clears all control state and sets buffer_size to 16, no clearing pass
`default_nettype none

module integer_to_roman_numeral_core #(
	parameter int VALUE_BITS = i2r_pkg::DEF_VALUE_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [i2r_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [i2r_pkg::DATA_W-1:0]   pwdata,
	output logic      [i2r_pkg::DATA_W-1:0]   prdata,
	output logic                              pready,
	i2r_value_if.sink                         value_ch,
	i2r_numeral_if.source                     numeral_ch
);
	import i2r_pkg::*;

	logic [CFG_W-1:0]    buf_size_q;
	logic                reg_hit;
	logic                q_push;
	logic [VALUE_BITS:0] q_push_data;
	logic                q_full;
	logic                q_pop;
	logic [VALUE_BITS:0] q_pop_data;
	logic                q_empty;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:2] == REG_BUFFER_SIZE);
	assign prdata  = reg_hit ? DATA_W'(buf_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			buf_size_q <= BUF_SIZE_RESET;
		else if (psel && penable && pwrite && pready && reg_hit)
			buf_size_q <= pwdata[CFG_W-1:0];
	end

	i2r_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_ch    (value_ch),
		.buffer_size (buf_size_q),
		.push        (q_push),
		.push_data   (q_push_data),
		.full        (q_full)
	);

	i2r_queue #(.WIDTH(VALUE_BITS + 1)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty)
	);

	i2r_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.pop_data   (q_pop_data),
		.pop        (q_pop),
		.numeral_ch (numeral_ch)
	);

endmodule

`default_nettype wire

@@ rtl/core/i2r_queue.sv @@
// short register queue between the classifier and the emitter
`default_nettype none

module i2r_queue #(
	parameter int WIDTH = i2r_pkg::DEF_VALUE_BITS + 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  empty
);
	import i2r_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

@@ rtl/core/i2r_front.sv @@
// front end: takes values, measures the numeral and decides pass or fail
`default_nettype none

`include "integer_to_roman_numeral_core_macros.svh"

module i2r_front #(
	parameter int VALUE_BITS = i2r_pkg::DEF_VALUE_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	i2r_value_if.sink                     value_ch,
	input  wire logic [i2r_pkg::CFG_W-1:0] buffer_size,
	output logic                          push,
	output logic [VALUE_BITS:0]           push_data,
	input  wire logic                     full
);
	import i2r_pkg::*;

	typedef enum logic [2:0] {
		FR_IDLE = 3'b001,
		FR_RUN  = 3'b010,
		FR_PUSH = 3'b100
	} front_state_t;

	front_state_t          st_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [VALUE_BITS-1:0] n_q;
	logic [LEN_W-1:0]      len_q;
	logic                  ok_q;

	logic [VALUE_BITS-1:0] v_in;
	logic                  in_take;
	logic [VAL_W-1:0]      n_ext;
	sym_idx_t              idx;
	logic [LEN_W-1:0]      need;
	logic [LEN_W-1:0]      len_nx;
	logic [VAL_W-1:0]      rem;
	logic                  fits;
	logic                  done;
	logic                  buf_ok;

	assign v_in    = value_ch.value[VALUE_BITS-1:0];
	assign push    = (st_q == FR_PUSH) && !full;
	assign value_ch.ready = (st_q == FR_IDLE) || push;
	assign in_take = value_ch.valid && value_ch.ready;
	assign push_data = {ok_q, v_q};

	// one greedy symbol per cycle
	assign n_ext  = VAL_W'(n_q);
	assign idx    = sym_sel(n_ext);
	assign need   = (sym_lo(idx) != '0) ? LEN_W'(2) : LEN_W'(1);
	assign len_nx = len_q + need;
	assign rem    = n_ext - sym_val(idx);
	assign fits   = (len_nx <= LEN_W'(MAX_CHARS));
	assign done   = (rem == '0);
	// room for the numeral and its terminator
	assign buf_ok = ((CFG_W'(len_nx) + CFG_W'(1)) <= buffer_size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FR_IDLE;
		end else begin
			case (st_q)
				FR_IDLE: begin
					if (in_take)
						st_q <= (v_in == '0) ? FR_PUSH : FR_RUN;
				end
				FR_RUN: begin
					if (!fits || done)
						st_q <= FR_PUSH;
				end
				FR_PUSH: begin
					if (in_take)
						st_q <= (v_in == '0) ? FR_PUSH : FR_RUN;
					else if (push)
						st_q <= FR_IDLE;
				end
				default: st_q <= FR_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			v_q   <= v_in;
			n_q   <= v_in;
			len_q <= '0;
			ok_q  <= 1'b0;
		end else if (st_q == FR_RUN) begin
			if (!fits) begin
				ok_q <= 1'b0;
			end else begin
				len_q <= len_nx;
				n_q   <= rem[VALUE_BITS-1:0];
				if (done)
					ok_q <= buf_ok;
			end
		end
	end

	`I2R_ASSERT_NXT(a_zero_fails, in_take && (v_in == '0), (st_q == FR_PUSH) && !ok_q)
	`I2R_ASSERT_IMP(a_run_nonzero, st_q == FR_RUN, n_q != '0)
	`I2R_ASSERT_IMP(a_len_bound, st_q == FR_RUN, len_q <= LEN_W'(MAX_CHARS))

endmodule

`default_nettype wire

@@ rtl/core/i2r_back.sv @@
// back end: spells out the numeral one character per cycle while the numeral channel is ready
`default_nettype none

`include "integer_to_roman_numeral_core_macros.svh"

module i2r_back #(
	parameter int VALUE_BITS = i2r_pkg::DEF_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  empty,
	input  wire logic [VALUE_BITS:0]   pop_data,
	output logic                       pop,
	i2r_numeral_if.source              numeral_ch
);
	import i2r_pkg::*;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_EMIT = 2'b10
	} back_state_t;

	back_state_t           st_q;
	logic [VALUE_BITS-1:0] n_q;
	logic                  ok_q;
	logic                  second_q;
	logic                  ovalid_q;
	logic [SYM_W-1:0]      sym_q;
	logic                  last_q;
	logic                  okout_q;

	logic                  adv;
	logic                  emit;
	logic [VAL_W-1:0]      n_ext;
	sym_idx_t              idx;
	logic                  two;
	logic [VAL_W-1:0]      rem;
	logic [SYM_W-1:0]      emit_sym;
	logic                  emit_last;
	logic                  emit_done;
	logic                  step_n;
	logic                  second_nx;

	assign adv   = !ovalid_q || numeral_ch.ready;
	assign emit  = (st_q == BK_EMIT) && adv;
	assign pop   = (st_q == BK_IDLE) && !empty;

	assign n_ext = VAL_W'(n_q);
	assign idx   = sym_sel(n_ext);
	assign two   = (sym_lo(idx) != '0);
	assign rem   = n_ext - sym_val(idx);

	always_comb begin
		emit_sym  = '0;
		emit_last = 1'b1;
		emit_done = 1'b1;
		step_n    = 1'b0;
		second_nx = 1'b0;
		if (!ok_q) begin
			// failure item: no symbol
			emit_sym = '0;
		end else if (second_q) begin
			emit_sym  = sym_lo(idx);
			emit_last = (rem == '0);
			emit_done = (rem == '0);
			step_n    = 1'b1;
		end else if (two) begin
			emit_sym  = sym_hi(idx);
			emit_last = 1'b0;
			emit_done = 1'b0;
			second_nx = 1'b1;
		end else begin
			emit_sym  = sym_hi(idx);
			emit_last = (rem == '0);
			emit_done = (rem == '0);
			step_n    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= BK_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (adv)
				ovalid_q <= (st_q == BK_EMIT);
			case (st_q)
				BK_IDLE: begin
					if (pop)
						st_q <= BK_EMIT;
				end
				BK_EMIT: begin
					if (emit && emit_done)
						st_q <= BK_IDLE;
				end
				default: st_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			n_q      <= pop_data[VALUE_BITS-1:0];
			ok_q     <= pop_data[VALUE_BITS];
			second_q <= 1'b0;
		end else if (emit) begin
			second_q <= second_nx;
			if (step_n)
				n_q <= rem[VALUE_BITS-1:0];
		end
		if (emit) begin
			sym_q   <= emit_sym;
			last_q  <= emit_last;
			okout_q <= ok_q;
		end
	end

	assign numeral_ch.valid  = ovalid_q;
	assign numeral_ch.symbol = sym_q;
	assign numeral_ch.last   = last_q;
	assign numeral_ch.ok     = okout_q;

	`I2R_ASSERT_IMP(a_fail_shape, ovalid_q && !okout_q, (sym_q == '0) && last_q)
	`I2R_ASSERT_IMP(a_second_pair, (st_q == BK_EMIT) && ok_q && second_q, two)
	`I2R_ASSERT_IMP(a_emit_nonzero, (st_q == BK_EMIT) && ok_q, n_q != '0)

endmodule

`default_nettype wire
